### design/det_pkg.sv
`default_nettype none

package det_pkg;

	localparam int TABLE_ENTRIES = 128;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int PTR_W = IDX_W + 1;
	localparam int SLOT_W = 7;

	localparam logic [7:0] NO_PARENT = 8'hFF;

	typedef enum logic [2:0] {
		ACT_ALLOC  = 3'd0,
		ACT_FREE   = 3'd1,
		ACT_WRITE  = 3'd2,
		ACT_LOOKUP = 3'd3,
		ACT_EXISTS = 3'd4,
		ACT_NEXT   = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOOK,
		ST_EXEC,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [63:0] owner;
		logic [7:0]  owner_tail;
		logic [63:0] fname;
		logic [7:0]  fname_tail;
	} name_t;

	typedef struct packed {
		logic [7:0]  parent;
		logic [1:0]  kind;
		logic [14:0] length;
	} attr_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [6:0]  index;
		logic [7:0]  parent;
		logic [1:0]  entry_type;
		logic [14:0] file_length;
		name_t       name;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        parent;
		logic [1:0]        kind;
		logic [14:0]       length;
	} rsp_t;

	typedef struct packed {
		logic             name_we;
		logic             attr_we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] raddr;
		name_t            name_wdata;
		attr_t            attr_wdata;
	} ram_cmd_t;

endpackage

`default_nettype wire

### design/det_req_if.sv
`default_nettype none

interface det_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic [6:0]         index;
	logic signed [7:0]  parent;
	logic [1:0]         entry_type;
	logic [14:0]        file_length;
	logic [63:0]        owner_low;
	logic [7:0]         owner_high;
	logic [63:0]        fname_low;
	logic [7:0]         fname_high;

	modport source (
		output valid, action, index, parent, entry_type, file_length,
		output owner_low, owner_high, fname_low, fname_high,
		input  ready
	);

	modport sink (
		input  valid, action, index, parent, entry_type, file_length,
		input  owner_low, owner_high, fname_low, fname_high,
		output ready
	);
endinterface

`default_nettype wire

### design/det_rsp_if.sv
`default_nettype none

interface det_rsp_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic [6:0]         slot;
	logic signed [7:0]  out_parent;
	logic [1:0]         out_type;
	logic [14:0]        out_length;

	modport source (
		output valid, found, slot, out_parent, out_type, out_length,
		input  ready
	);

	modport sink (
		input  valid, found, slot, out_parent, out_type, out_length,
		output ready
	);
endinterface

`default_nettype wire

### design/det_ram.sv
`default_nettype none

module det_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output      logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### design/det_ctrl.sv
`default_nettype none

module det_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire det_pkg::req_t     req,
	output      logic              req_ready,
	input  wire logic              out_free,
	output      logic              res_valid,
	output      det_pkg::rsp_t     res,
	output      det_pkg::ram_cmd_t ram,
	input  wire det_pkg::name_t    name_rd,
	input  wire det_pkg::attr_t    attr_rd
);

	det_pkg::state_t state_q, state_d;
	det_pkg::req_t   req_q;
	det_pkg::action_t act_q, act_in;
	det_pkg::rsp_t   res_q, res_d;

	logic [det_pkg::PTR_W-1:0]         addr_q, addr_start;
	logic                              pend_s1;
	logic [det_pkg::IDX_W-1:0]         pidx_s1;
	logic [det_pkg::TABLE_ENTRIES-1:0] valid_q;

	logic accept, in_range_in, in_range_q, used_q, scan_end;
	logic owner_ok, hit_raw, hit, alloc_claim;

	assign act_q  = det_pkg::action_t'(req_q.action);
	assign act_in = det_pkg::action_t'(req.action);
	assign accept = req_valid && req_ready;

	assign in_range_in = 32'(req.index) < det_pkg::TABLE_ENTRIES;
	assign in_range_q  = 32'(req_q.index) < det_pkg::TABLE_ENTRIES;
	assign used_q      = in_range_q && valid_q[det_pkg::IDX_W'(req_q.index)];
	assign scan_end    = 32'(addr_q) >= det_pkg::TABLE_ENTRIES;

	// compare stage of the scan, one entry per cycle
	assign owner_ok = valid_q[pidx_s1]
		&& name_rd.owner == req_q.name.owner
		&& name_rd.owner_tail == req_q.name.owner_tail
		&& attr_rd.parent == req_q.parent;

	always_comb begin
		case (act_q)
			det_pkg::ACT_ALLOC:  hit_raw = !valid_q[pidx_s1];
			det_pkg::ACT_EXISTS: hit_raw = owner_ok
				&& name_rd.fname == req_q.name.fname
				&& name_rd.fname_tail == req_q.name.fname_tail;
			det_pkg::ACT_NEXT:   hit_raw = owner_ok;
			default:             hit_raw = 1'b0;
		endcase
	end

	assign hit         = (state_q == det_pkg::ST_SCAN) && pend_s1 && hit_raw;
	assign alloc_claim = hit && act_q == det_pkg::ACT_ALLOC;

	always_comb begin
		if (act_in == det_pkg::ACT_NEXT) begin
			addr_start = in_range_in ? det_pkg::PTR_W'(req.index)
				: det_pkg::PTR_W'(det_pkg::TABLE_ENTRIES);
		end else begin
			addr_start = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			det_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (act_in)
						det_pkg::ACT_ALLOC,
						det_pkg::ACT_EXISTS,
						det_pkg::ACT_NEXT:   state_d = det_pkg::ST_SCAN;
						det_pkg::ACT_LOOKUP: state_d = det_pkg::ST_LOOK;
						default:             state_d = det_pkg::ST_EXEC;
					endcase
				end
			end
			det_pkg::ST_SCAN: begin
				if (hit || (!pend_s1 && scan_end)) begin
					state_d = det_pkg::ST_RESP;
				end
			end
			det_pkg::ST_LOOK: state_d = det_pkg::ST_RESP;
			det_pkg::ST_EXEC: state_d = det_pkg::ST_RESP;
			det_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = det_pkg::ST_IDLE;
				end
			end
			default: state_d = det_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = state_q == det_pkg::ST_IDLE;
		res_valid = (state_q == det_pkg::ST_RESP) && out_free;
		res       = res_q;

		ram.raddr = (state_q == det_pkg::ST_IDLE) ? det_pkg::IDX_W'(req.index)
			: addr_q[det_pkg::IDX_W-1:0];
		ram.name_we = (state_q == det_pkg::ST_EXEC) && act_q == det_pkg::ACT_WRITE
			&& used_q;
		ram.attr_we = ram.name_we || alloc_claim;
		ram.waddr   = (state_q == det_pkg::ST_SCAN) ? pidx_s1
			: det_pkg::IDX_W'(req_q.index);
		ram.name_wdata = req_q.name;
		if (state_q == det_pkg::ST_SCAN) begin
			ram.attr_wdata = '{parent: det_pkg::NO_PARENT, kind: 2'd0, length: 15'd0};
		end else begin
			ram.attr_wdata = '{parent: req_q.parent, kind: req_q.entry_type,
				length: req_q.file_length};
		end
	end

	always_comb begin
		res_d = '{found: 1'b0, slot: '0, parent: det_pkg::NO_PARENT,
			kind: 2'd0, length: 15'd0};
		case (state_q)
			det_pkg::ST_SCAN: begin
				if (hit) begin
					res_d.found = 1'b1;
					res_d.slot  = det_pkg::SLOT_W'(pidx_s1);
				end
			end
			det_pkg::ST_LOOK: begin
				if (used_q) begin
					res_d.found  = 1'b1;
					res_d.slot   = req_q.index;
					res_d.parent = attr_rd.parent;
					res_d.kind   = attr_rd.kind;
					res_d.length = attr_rd.length;
				end
			end
			det_pkg::ST_EXEC: begin
				if (used_q && (act_q == det_pkg::ACT_FREE
					|| act_q == det_pkg::ACT_WRITE)) begin
					res_d.found = 1'b1;
					res_d.slot  = req_q.index;
				end
			end
			default: res_d = res_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= det_pkg::ST_IDLE;
			valid_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == det_pkg::ST_SCAN) && !scan_end && !hit;
			if (alloc_claim) begin
				valid_q[pidx_s1] <= 1'b1;
			end
			if (state_q == det_pkg::ST_EXEC && act_q == det_pkg::ACT_FREE && used_q) begin
				valid_q[det_pkg::IDX_W'(req_q.index)] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req;
			addr_q <= addr_start;
		end else if (state_q == det_pkg::ST_SCAN && !scan_end) begin
			addr_q <= addr_q + 1'b1;
		end
		if (state_q == det_pkg::ST_SCAN) begin
			pidx_s1 <= addr_q[det_pkg::IDX_W-1:0];
		end
		res_q <= res_d;
	end

	a_claim_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_claim |=> valid_q[$past(pidx_s1)])
		else $error("claimed slot not marked in use");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && state_q == det_pkg::ST_SCAN)
			|-> 32'(pidx_s1) < det_pkg::TABLE_ENTRIES)
		else $error("scan compared an entry beyond the table");

	a_found_is_used: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.found && act_q != det_pkg::ACT_FREE)
			|-> valid_q[det_pkg::IDX_W'(res.slot)])
		else $error("result names an entry that is not in use");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ram.name_we || ram.attr_we) |-> state_q != det_pkg::ST_IDLE
			&& state_q != det_pkg::ST_RESP)
		else $error("table written outside a request");

endmodule

`default_nettype wire

### design/directory_entry_table.sv
// directory entry table
//
// req carries one request word per handshake (valid and ready both high at a
// rising clk edge): allocate, free, write, lookup, exists or next child, with
// the entry index, parent, type, length and the two 9-byte names.
// rsp returns exactly one result word per request, in request order.
//
// requests are served one at a time. free, write, lookup and unknown actions
// pass through an execute or lookup state and the response state; req is
// ready again as their result word appears on rsp. allocate, exists and next
// child scan the table one entry per cycle through a registered memory read
// and then wait in the response state, with req ready again as the word
// appears on rsp; a scan stops at its first match.
//
// the names sit in one memory, parent, type and length in another; the in-use
// marks are flip-flops. arst_n empties the table at once, no sweep is needed.
//
// a finished result goes into the rsp output register. req may accept the
// next request while that word still waits; if rsp stays stalled, the next
// result is held inside and req stays low until the output register frees.
`default_nettype none

module directory_entry_table (
	input wire logic clk,
	input wire logic arst_n,
	det_req_if.sink  req,
	det_rsp_if.source rsp
);

	det_pkg::req_t     req_word;
	det_pkg::rsp_t     res, rsp_q;
	det_pkg::ram_cmd_t ram;
	det_pkg::name_t    name_rd;
	det_pkg::attr_t    attr_rd;
	logic              req_ready, res_valid, out_free, rsp_valid_q;

	always_comb begin
		req_word.action          = req.action;
		req_word.index           = req.index;
		req_word.parent          = req.parent;
		req_word.entry_type      = req.entry_type;
		req_word.file_length     = req.file_length;
		req_word.name.owner      = req.owner_low;
		req_word.name.owner_tail = req.owner_high;
		req_word.name.fname      = req.fname_low;
		req_word.name.fname_tail = req.fname_high;
	end

	assign req.ready = req_ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	det_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req       (req_word),
		.req_ready (req_ready),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.ram       (ram),
		.name_rd   (name_rd),
		.attr_rd   (attr_rd)
	);

	det_ram #(
		.WIDTH ($bits(det_pkg::name_t)),
		.DEPTH (det_pkg::TABLE_ENTRIES)
	) u_name_ram (
		.clk   (clk),
		.we    (ram.name_we),
		.waddr (ram.waddr),
		.wdata (ram.name_wdata),
		.raddr (ram.raddr),
		.rdata (name_rd)
	);

	det_ram #(
		.WIDTH ($bits(det_pkg::attr_t)),
		.DEPTH (det_pkg::TABLE_ENTRIES)
	) u_attr_ram (
		.clk   (clk),
		.we    (ram.attr_we),
		.waddr (ram.waddr),
		.wdata (ram.attr_wdata),
		.raddr (ram.raddr),
		.rdata (attr_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.found      = rsp_q.found;
	assign rsp.slot       = rsp_q.slot;
	assign rsp.out_parent = rsp_q.parent;
	assign rsp.out_type   = rsp_q.kind;
	assign rsp.out_length = rsp_q.length;

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import det_pkg::*;

	localparam logic [2:0]  ACT_BAD6 = 3'd6;
	localparam logic [2:0]  ACT_BAD7 = 3'd7;
	localparam logic [1:0]  TYPE_NONE = 2'd0;
	localparam logic [1:0]  TYPE_DIR = 2'd1;
	localparam logic [1:0]  TYPE_FILE = 2'd2;
	localparam logic [1:0]  TYPE_OTHER = 2'd3;
	localparam logic [71:0] NAME_ZERO = '0;
	localparam logic [71:0] NAME_ONES = '1;
	localparam int RANDOM_PER_PHASE = 242;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 140;
	localparam int STALL_LIMIT = 5000;

	class table_scoreboard;
		bit    in_use[TABLE_ENTRIES];
		bit    named[TABLE_ENTRIES];
		name_t names[TABLE_ENTRIES];
		attr_t attrs[TABLE_ENTRIES];
		rsp_t  pending_answers[$];
		int    errors;
		int    reported;
		int    answers_checked;
		int    action_count[8];
		int    full_allocs;
		int    exists_hits;
		int    child_hits;

		function new();
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				in_use[k] = 1'b0;
				named[k] = 1'b0;
				names[k] = '0;
				attrs[k] = empty_attr();
			end
			for (int k = 0; k < 8; k++)
				action_count[k] = 0;
			errors = 0;
			reported = 0;
			answers_checked = 0;
			full_allocs = 0;
			exists_hits = 0;
			child_hits = 0;
		endfunction

		function attr_t empty_attr();
			attr_t a;
			a.parent = NO_PARENT;
			a.kind = '0;
			a.length = '0;
			return a;
		endfunction

		function bit owner_hit(int k, req_t r);
			return in_use[k] && names[k].owner == r.name.owner &&
				names[k].owner_tail == r.name.owner_tail && attrs[k].parent == r.parent;
		endfunction

		function int used_count();
			int n;
			n = 0;
			for (int k = 0; k < TABLE_ENTRIES; k++)
				n += in_use[k];
			return n;
		endfunction

		// predicted answer for one accepted request word
		function void note_request(req_t r);
			rsp_t ans;
			int   idx;
			bit   used;
			ans.found = 1'b0;
			ans.slot = '0;
			ans.parent = NO_PARENT;
			ans.kind = '0;
			ans.length = '0;
			idx = r.index;
			used = idx < TABLE_ENTRIES && in_use[idx];
			action_count[r.action]++;
			case (r.action)
			ACT_ALLOC: begin
				for (int k = 0; k < TABLE_ENTRIES; k++) begin
					if (!in_use[k]) begin
						in_use[k] = 1'b1;
						attrs[k] = empty_attr();
						ans.found = 1'b1;
						ans.slot = SLOT_W'(k);
						break;
					end
				end
				if (!ans.found)
					full_allocs++;
			end
			ACT_FREE: begin
				if (used) begin
					in_use[idx] = 1'b0;
					attrs[idx] = empty_attr();
					ans.found = 1'b1;
					ans.slot = SLOT_W'(idx);
				end
			end
			ACT_WRITE: begin
				if (used) begin
					names[idx] = r.name;
					named[idx] = 1'b1;
					attrs[idx].parent = r.parent;
					attrs[idx].kind = r.entry_type;
					attrs[idx].length = r.file_length;
					ans.found = 1'b1;
					ans.slot = SLOT_W'(idx);
				end
			end
			ACT_LOOKUP: begin
				if (used) begin
					ans.found = 1'b1;
					ans.slot = SLOT_W'(idx);
					ans.parent = attrs[idx].parent;
					ans.kind = attrs[idx].kind;
					ans.length = attrs[idx].length;
				end
			end
			ACT_EXISTS: begin
				for (int k = 0; k < TABLE_ENTRIES; k++) begin
					if (owner_hit(k, r) && names[k].fname == r.name.fname &&
						names[k].fname_tail == r.name.fname_tail) begin
						ans.found = 1'b1;
						ans.slot = SLOT_W'(k);
						break;
					end
				end
				exists_hits += ans.found;
			end
			ACT_NEXT: begin
				for (int k = idx; k < TABLE_ENTRIES; k++) begin
					if (owner_hit(k, r)) begin
						ans.found = 1'b1;
						ans.slot = SLOT_W'(k);
						break;
					end
				end
				child_hits += ans.found;
			end
			default: ;
			endcase
			pending_answers.push_back(ans);
		endfunction

		function void check_answer(rsp_t got);
			rsp_t want;
			answers_checked++;
			if (pending_answers.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected result word: found=%0d slot=%0d parent=%02h",
						got.found, got.slot, got.parent);
				end
				return;
			end
			want = pending_answers.pop_front();
			if (got.found !== want.found || got.slot !== want.slot ||
				got.parent !== want.parent || got.kind !== want.kind ||
				got.length !== want.length) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("result %0d mismatch: expected found=%0d slot=%0d parent=%02h",
						answers_checked, want.found, want.slot, want.parent,
						" type=%0d length=%0d", want.kind, want.length);
					$display("  got found=%0d slot=%0d parent=%02h type=%0d length=%0d",
						got.found, got.slot, got.parent, got.kind, got.length);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	det_req_if req_bus();
	det_rsp_if rsp_bus();

	directory_entry_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	table_scoreboard sb = new();

	int          send_idle_pct = 34;
	int          recv_idle_pct = 47;
	bit          hold_request = 1'b0;
	logic [71:0] name_pool[6];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_request(input req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.action <= r.action;
		req_bus.index <= r.index;
		req_bus.parent <= r.parent;
		req_bus.entry_type <= r.entry_type;
		req_bus.file_length <= r.file_length;
		req_bus.owner_low <= r.name.owner;
		req_bus.owner_high <= r.name.owner_tail;
		req_bus.fname_low <= r.name.fname;
		req_bus.fname_high <= r.name.fname_tail;
		req_bus.valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_bus.ready);
		sb.note_request(r);
	endtask

	function automatic req_t make_req(logic [2:0] act, int idx, logic [7:0] par,
		logic [1:0] typ, logic [14:0] len, logic [71:0] own, logic [71:0] fn);
		req_t r;
		r.action = act;
		r.index = 7'(idx);
		r.parent = par;
		r.entry_type = typ;
		r.file_length = len;
		{r.name.owner, r.name.owner_tail} = own;
		{r.name.fname, r.name.fname_tail} = fn;
		return r;
	endfunction

	function automatic logic [71:0] pick_name();
		if ($urandom_range(0, 3) == 0)
			return {$urandom, $urandom, 8'($urandom)};
		return name_pool[$urandom_range(0, 5)];
	endfunction

	function automatic logic [7:0] any_parent();
		case ($urandom_range(0, 4))
		0: return NO_PARENT;
		1: return 8'd0;
		2: return 8'd1;
		default: return 8'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic int pick_used();
		int q[$];
		for (int k = 0; k < TABLE_ENTRIES; k++)
			if (sb.in_use[k])
				q.push_back(k);
		if (q.size() == 0)
			return -1;
		return q[$urandom_range(0, q.size() - 1)];
	endfunction

	// entry in use whose names were never set
	function automatic int first_blank();
		for (int k = 0; k < TABLE_ENTRIES; k++)
			if (sb.in_use[k] && !sb.named[k])
				return k;
		return -1;
	endfunction

	function automatic req_t random_request(bit grow);
		req_t r;
		int   roll;
		int   k;
		int   b;
		r = make_req(ACT_LOOKUP, $urandom_range(0, 127), any_parent(),
			2'($urandom_range(0, 3)), 15'($urandom_range(0, 32767)),
			pick_name(), pick_name());
		roll = $urandom_range(0, 99);
		if (roll < 4)
			r.action = (roll < 2) ? ACT_BAD6 : ACT_BAD7;
		else if (roll < (grow ? 50 : 14))
			r.action = ACT_ALLOC;
		else if (roll < (grow ? 56 : 50))
			r.action = ACT_FREE;
		else if (roll < 72)
			r.action = ACT_WRITE;
		else if (roll < 80)
			r.action = ACT_LOOKUP;
		else if (roll < 90)
			r.action = ACT_EXISTS;
		else
			r.action = ACT_NEXT;
		b = first_blank();
		k = pick_used();
		if ((r.action == ACT_EXISTS || r.action == ACT_NEXT) && b >= 0) begin
			r.action = ACT_WRITE;
			r.index = 7'(b);
		end else begin
			case (r.action)
			ACT_FREE, ACT_LOOKUP: begin
				if (k >= 0 && $urandom_range(0, 4) != 0)
					r.index = 7'(k);
			end
			ACT_WRITE: begin
				if (b >= 0 && $urandom_range(0, 3) != 0)
					r.index = 7'(b);
				else if (k >= 0 && $urandom_range(0, 5) != 0)
					r.index = 7'(k);
			end
			ACT_EXISTS: begin
				if (k >= 0 && $urandom_range(0, 3) != 0) begin
					r.name = sb.names[k];
					r.parent = sb.attrs[k].parent;
					// near miss on one name bit
					if ($urandom_range(0, 4) == 0)
						r.name[$urandom_range(0, 143)] ^= 1'b1;
				end
			end
			ACT_NEXT: begin
				if (k >= 0 && $urandom_range(0, 3) != 0) begin
					r.name.owner = sb.names[k].owner;
					r.name.owner_tail = sb.names[k].owner_tail;
					r.parent = sb.attrs[k].parent;
					r.index = 7'($urandom_range(0, k));
				end
			end
			default: ;
			endcase
		end
		return r;
	endfunction

	initial begin : answer_sink
		rsp_t got;
		int   hold_left;
		hold_left = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
				got.found = rsp_bus.found;
				got.slot = rsp_bus.slot;
				got.parent = rsp_bus.out_parent;
				got.kind = rsp_bus.out_type;
				got.length = rsp_bus.out_length;
				sb.check_answer(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_bus.valid && req_bus.ready) ||
				(rsp_bus.valid && rsp_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no handshake for %0d cycles", STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		bit grow;
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.action <= ACT_ALLOC;
		req_bus.index <= '0;
		req_bus.parent <= NO_PARENT;
		req_bus.entry_type <= TYPE_NONE;
		req_bus.file_length <= '0;
		req_bus.owner_low <= '0;
		req_bus.owner_high <= '0;
		req_bus.fname_low <= '0;
		req_bus.fname_high <= '0;
		name_pool[0] = NAME_ZERO;
		name_pool[1] = NAME_ONES;
		for (int k = 2; k < 6; k++)
			name_pool[k] = {$urandom, $urandom, 8'($urandom)};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		send_request(make_req(ACT_LOOKUP, 0, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_FREE, 127, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_WRITE, 5, 8'd3, TYPE_FILE, 100, NAME_ONES, NAME_ONES));
		send_request(make_req(ACT_EXISTS, 0, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_NEXT, 127, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		// two entries at the field extremes
		send_request(make_req(ACT_ALLOC, 0, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_ALLOC, 0, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_WRITE, 0, NO_PARENT, TYPE_DIR, 15'h7FFF, NAME_ONES,
			NAME_ONES));
		send_request(make_req(ACT_WRITE, 1, 8'd0, TYPE_FILE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_LOOKUP, 0, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_LOOKUP, 1, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_EXISTS, 0, NO_PARENT, TYPE_NONE, 0, NAME_ONES, NAME_ONES));
		send_request(make_req(ACT_EXISTS, 0, 8'd0, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_NEXT, 0, 8'd0, TYPE_NONE, 0, NAME_ZERO, NAME_ONES));
		send_request(make_req(ACT_NEXT, 2, 8'd0, TYPE_NONE, 0, NAME_ZERO, NAME_ONES));
		send_request(make_req(ACT_BAD6, 0, NO_PARENT, TYPE_OTHER, 15'h7FFF, NAME_ONES,
			NAME_ONES));
		send_request(make_req(ACT_BAD7, 1, 8'd0, TYPE_DIR, 1, NAME_ZERO, NAME_ZERO));
		// freed and reclaimed entry keeps its names
		send_request(make_req(ACT_FREE, 0, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_LOOKUP, 0, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_ALLOC, 0, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_LOOKUP, 0, NO_PARENT, TYPE_NONE, 0, NAME_ZERO, NAME_ZERO));
		send_request(make_req(ACT_EXISTS, 0, NO_PARENT, TYPE_NONE, 0, NAME_ONES, NAME_ONES));
		send_request(make_req(ACT_WRITE, 127, 8'd1, TYPE_DIR, 7, NAME_ONES, NAME_ZERO));
		send_request(make_req(ACT_WRITE, 1, 8'd127, TYPE_OTHER, 15'($urandom),
			{$urandom, $urandom, 8'($urandom)}, {$urandom, $urandom, 8'($urandom)}));

		grow = 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				send_idle_pct = 34;
				recv_idle_pct = 47;
			end
			1: begin
				send_idle_pct = 47;
				recv_idle_pct = 34;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_request = 1'b1;
			end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				send_request(random_request(grow));
				if (sb.used_count() == TABLE_ENTRIES && $urandom_range(0, 5) == 0)
					grow = 1'b0;
				else if (sb.used_count() < 6)
					grow = 1'b1;
			end
		end
		req_bus.valid <= 1'b0;

		while (sb.pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered alloc %0d (table full %0d), free %0d, write %0d, lookup %0d",
			sb.action_count[ACT_ALLOC], sb.full_allocs, sb.action_count[ACT_FREE],
			sb.action_count[ACT_WRITE], sb.action_count[ACT_LOOKUP]);
		$display("exists %0d (hits %0d), next child %0d (hits %0d), unknown %0d, checked %0d",
			sb.action_count[ACT_EXISTS], sb.exists_hits, sb.action_count[ACT_NEXT],
			sb.child_hits, sb.action_count[ACT_BAD6] + sb.action_count[ACT_BAD7],
			sb.answers_checked);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
